// ===== sv/twn80_pkg.sv =====
// Shared types, constants and table functions for the TWINE-80 cipher block.
// No dependencies; imported by the key schedule, round unit and top level.
package twn80_pkg;

  localparam int NUM_RK = 36;
  localparam int RK_AW  = 6;

  localparam logic [RK_AW-1:0] LAST_RK = RK_AW'(NUM_RK - 1);
  localparam logic [5:0]       MAX_RND = 6'(NUM_RK - 1);

  localparam logic [1:0] CFG_KEY_LOW     = 2'd0;
  localparam logic [1:0] CFG_KEY_HIGH    = 2'd1;
  localparam logic [1:0] CFG_ROUND_COUNT = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_RUN,
    ST_DONE
  } state_t;

  // key schedule status and round key store write port
  typedef struct packed {
    logic             busy;
    logic             wr_en;
    logic [RK_AW-1:0] wr_addr;
    logic [31:0]      wr_data;
  } ks_stat_t;

  function automatic logic [3:0] sbox(input logic [3:0] v);
    logic [3:0] s;
    case (v)
      4'h0: s = 4'hC;
      4'h1: s = 4'h0;
      4'h2: s = 4'hF;
      4'h3: s = 4'hA;
      4'h4: s = 4'h2;
      4'h5: s = 4'hB;
      4'h6: s = 4'h9;
      4'h7: s = 4'h5;
      4'h8: s = 4'h8;
      4'h9: s = 4'h3;
      4'hA: s = 4'hD;
      4'hB: s = 4'h7;
      4'hC: s = 4'h1;
      4'hD: s = 4'hE;
      4'hE: s = 4'h6;
      4'hF: s = 4'h4;
      default: s = 4'h0;
    endcase
    return s;
  endfunction

  // encryption shuffle: nibble j moves to position shuf(j)
  function automatic logic [3:0] shuf(input logic [3:0] j);
    logic [3:0] p;
    case (j)
      4'd0:  p = 4'd5;
      4'd1:  p = 4'd0;
      4'd2:  p = 4'd1;
      4'd3:  p = 4'd4;
      4'd4:  p = 4'd7;
      4'd5:  p = 4'd12;
      4'd6:  p = 4'd3;
      4'd7:  p = 4'd8;
      4'd8:  p = 4'd13;
      4'd9:  p = 4'd6;
      4'd10: p = 4'd9;
      4'd11: p = 4'd2;
      4'd12: p = 4'd15;
      4'd13: p = 4'd10;
      4'd14: p = 4'd11;
      4'd15: p = 4'd14;
      default: p = 4'd0;
    endcase
    return p;
  endfunction

  function automatic logic [5:0] rcon(input logic [RK_AW-1:0] i);
    logic [5:0] c;
    case (i)
      6'd0:  c = 6'h01;
      6'd1:  c = 6'h02;
      6'd2:  c = 6'h04;
      6'd3:  c = 6'h08;
      6'd4:  c = 6'h10;
      6'd5:  c = 6'h20;
      6'd6:  c = 6'h03;
      6'd7:  c = 6'h06;
      6'd8:  c = 6'h0C;
      6'd9:  c = 6'h18;
      6'd10: c = 6'h30;
      6'd11: c = 6'h23;
      6'd12: c = 6'h05;
      6'd13: c = 6'h0A;
      6'd14: c = 6'h14;
      6'd15: c = 6'h28;
      6'd16: c = 6'h13;
      6'd17: c = 6'h26;
      6'd18: c = 6'h0F;
      6'd19: c = 6'h1E;
      6'd20: c = 6'h3C;
      6'd21: c = 6'h3B;
      6'd22: c = 6'h35;
      6'd23: c = 6'h29;
      6'd24: c = 6'h11;
      6'd25: c = 6'h22;
      6'd26: c = 6'h07;
      6'd27: c = 6'h0E;
      6'd28: c = 6'h1C;
      6'd29: c = 6'h38;
      6'd30: c = 6'h33;
      6'd31: c = 6'h25;
      6'd32: c = 6'h09;
      6'd33: c = 6'h12;
      6'd34: c = 6'h24;
      default: c = 6'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== sv/twine80_block_cipher.sv =====
// TWINE-80 block cipher, one round per cycle through a shared round unit.
// A new block is taken only in idle, after the previous result has been loaded for output.
// The round count R is clamped to 35; each block runs R+1 rounds, 36 at the full count.
// Reset and every key write run the key schedule, with no block taken meanwhile.
// Synchronous active-high reset; keys clear to zero, round count to 35.
// Depends on twn80_pkg, twn80_key_sched, twn80_round.
module twine80_block_cipher import twn80_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        blk_valid,
  output logic        blk_stall,
  input  logic        kind,
  input  logic [63:0] data_block,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [63:0] result_block,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  state_t           state;
  state_t           state_next;
  logic [63:0]      key_low;
  logic [15:0]      key_high;
  logic [5:0]       round_count;
  logic [5:0]       rounds_eff;
  logic             ks_start;
  logic             ks_pending;
  ks_stat_t         ks_st;
  logic [31:0]      rk_mem [NUM_RK];
  logic [31:0]      rk_q;
  logic [63:0]      x;
  logic [63:0]      rnd_out;
  logic             dec;
  logic [5:0]       step;
  logic [RK_AW-1:0] kidx;
  logic             last;
  logic             more_keys;
  logic             accept;
  logic             cfg_wr;
  logic             res_load;

  assign rounds_eff = (round_count > MAX_RND) ? MAX_RND : round_count;
  assign last       = (step == rounds_eff);
  assign more_keys  = ({1'b0, step} + 7'd1) < {1'b0, rounds_eff};
  assign ks_pending = ks_start | ks_st.busy;
  assign accept     = blk_valid & ~blk_stall;
  assign cfg_wr     = cfg_valid & cfg_ready;
  // an offered block goes first, so no register changes under a starting block
  assign cfg_ready  = (state == ST_IDLE) & ~ks_pending & ~blk_valid;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_low     <= '0;
      key_high    <= '0;
      round_count <= MAX_RND;
      ks_start    <= 1'b1;
    end else begin
      ks_start <= cfg_wr & ((cfg_index == CFG_KEY_LOW) | (cfg_index == CFG_KEY_HIGH));
      if (cfg_wr) begin
        case (cfg_index)
          CFG_KEY_LOW:     key_low     <= cfg_data;
          CFG_KEY_HIGH:    key_high    <= cfg_data[15:0];
          CFG_ROUND_COUNT: round_count <= cfg_data[5:0];
          default: ;
        endcase
      end
    end
  end

  twn80_key_sched u_ks (
    .clk   (clk),
    .rst   (rst),
    .start (ks_start),
    .key   ({key_high, key_low}),
    .stat  (ks_st)
  );

  // round key store
  always_ff @(posedge clk) begin
    if (ks_st.wr_en) begin
      rk_mem[ks_st.wr_addr] <= ks_st.wr_data;
    end
    rk_q <= rk_mem[kidx];
  end

  twn80_round u_round (
    .blk     (x),
    .rk      (rk_q),
    .dec     (dec),
    .perm    (~last),
    .blk_out (rnd_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    blk_stall  = 1'b1;
    res_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        blk_stall = ks_pending;
        if (blk_valid && !ks_pending) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: state_next = ST_RUN;
      ST_RUN: begin
        if (last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!res_valid || !res_stall) begin
          res_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath: kidx runs one key ahead of the round in use
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          x    <= data_block;
          dec  <= kind;
          step <= '0;
          kidx <= kind ? rounds_eff : '0;
        end
      end
      ST_FETCH: begin
        if (rounds_eff != '0) begin
          kidx <= dec ? kidx - 1'b1 : kidx + 1'b1;
        end
      end
      ST_RUN: begin
        x <= rnd_out;
        if (!last) begin
          step <= step + 1'b1;
        end
        if (more_keys) begin
          kidx <= dec ? kidx - 1'b1 : kidx + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result_block <= x;
    end
  end

  // a block is only taken when the key store is settled
  a_accept_fetch: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_FETCH))
    else $error("block transfer did not start a fetch");

  a_ks_idle: assert property (@(posedge clk) disable iff (rst)
    ks_st.busy |-> (state == ST_IDLE))
    else $error("key schedule running during a block");

  a_res_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state == ST_DONE))
    else $error("result appeared without a finished block");

  a_kidx_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (kidx <= LAST_RK))
    else $error("round key index out of range");

endmodule

// ===== sv/twn80_key_sched.sv =====
// Iterative TWINE-80 key schedule: one 32-bit round key per cycle.
// Depends on twn80_pkg; writes the round key store held in the top level.
module twn80_key_sched import twn80_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [79:0] key,
  output ks_stat_t    stat
);

  logic             busy;
  logic [RK_AW-1:0] cnt;
  logic [79:0]      w;
  logic [79:0]      w_next;
  logic [3:0]       wn [20];
  logic [3:0]       un [20];
  logic [3:0]       tn [20];
  logic [5:0]       rc;

  always_comb begin
    rc = rcon(cnt);
    for (int i = 0; i < 20; i++) begin
      wn[i] = w[4*i +: 4];
    end
    un = wn;
    un[1]  = wn[1] ^ sbox(wn[0]);
    un[4]  = wn[4] ^ sbox(wn[16]);
    un[7]  = wn[7] ^ {1'b0, rc[5:3]};
    un[19] = wn[19] ^ {1'b0, rc[2:0]};
    // rotate first four nibbles by one, then the whole word by four
    tn = un;
    tn[0] = un[1];
    tn[1] = un[2];
    tn[2] = un[3];
    tn[3] = un[0];
    for (int k = 0; k < 20; k++) begin
      w_next[4*k +: 4] = (k < 16) ? tn[k + 4] : tn[k - 16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      if (cnt == LAST_RK) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      w <= key;
    end else if (busy) begin
      w <= w_next;
    end
  end

  always_comb begin
    stat.busy    = busy;
    stat.wr_en   = busy;
    stat.wr_addr = cnt;
    stat.wr_data = {wn[16], wn[15], wn[14], wn[13], wn[6], wn[4], wn[3], wn[1]};
  end

endmodule

// ===== sv/twn80_round.sv =====
// TWINE round unit: F-function followed by the forward or inverse shuffle, skipped when perm is low.
// Depends on twn80_pkg; shared by every round under the top level sequencer.
module twn80_round import twn80_pkg::*; (
  input  logic [63:0] blk,
  input  logic [31:0] rk,
  input  logic        dec,
  input  logic        perm,
  output logic [63:0] blk_out
);

  logic [3:0] xn [16];
  logic [3:0] yn [16];

  always_comb begin
    for (int k = 0; k < 16; k++) begin
      xn[k] = blk[4*k +: 4];
    end
    for (int j = 0; j < 8; j++) begin
      xn[2*j+1] = blk[4*(2*j+1) +: 4] ^ sbox(blk[8*j +: 4] ^ rk[4*j +: 4]);
    end
    yn = xn;
    if (perm) begin
      for (int k = 0; k < 16; k++) begin
        if (dec) begin
          yn[k] = xn[shuf(4'(k))];
        end else begin
          yn[shuf(4'(k))] = xn[k];
        end
      end
    end
    for (int k = 0; k < 16; k++) begin
      blk_out[4*k +: 4] = yn[k];
    end
  end

endmodule
